// ===== sv/triangle_min_path_sum_unit_assert.svh =====
// ----------------------------------------------------------------------------
// triangle_min_path_sum_unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIN_PATH_SUM_UNIT_ASSERT_SVH
`define TRIANGLE_MIN_PATH_SUM_UNIT_ASSERT_SVH

// generic implication check
`define TMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a signal holds across a stalled cycle
`define TMPS_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== sv/tmps_pkg.sv =====
// ----------------------------------------------------------------------------
// tmps_pkg
// Types, sizes and helpers shared by the triangle minimum path sum unit.
// ----------------------------------------------------------------------------
package tmps_pkg;

  // row capacity of the row store
  localparam int MAX_ROWS = 256;
  localparam int ADDR_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_W    = $clog2(MAX_ROWS + 1);
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 24;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // one element handed from the counter stage to the sum stage
  typedef struct packed {
    logic              last;
    logic              err;
    logic              wr;
    logic              top;
    logic              first;
    logic              right;
    logic [ADDR_W-1:0] addr;
    val_t              value;
  } tmps_req_t;

  // sum stage status seen by the handshake logic
  typedef struct packed {
    logic busy;
    logic last;
    sum_t min_total;
    logic shape_error;
  } tmps_stat_t;

  // element plus neighbor sum, clamped to the sum range
  function automatic sum_t sat_add(val_t v, sum_t b);
    logic signed [SUM_W:0] s;
    s = {{(SUM_W+1-VAL_W){v[VAL_W-1]}}, v} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/tmps_sum_stage.sv =====
// ----------------------------------------------------------------------------
// tmps_sum_stage
// Row store with registered read, neighbor selection, saturating add,
// write back and running row minimum.
// ----------------------------------------------------------------------------
module tmps_sum_stage
  import tmps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  tmps_req_t  req_i,
  input  logic       adv_i,
  output tmps_stat_t stat_o
);

  logic      s1_valid_r;
  tmps_req_t s1_req_r;
  logic      fwd_r;
  sum_t      fwd_data_r;
  sum_t      rd_q_r;
  sum_t      left_r;
  sum_t      row_min_r;
  sum_t      mem [MAX_ROWS];

  sum_t above;
  sum_t best;
  sum_t sum;
  sum_t min_new;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load_i) begin
      s1_valid_r <= 1'b1;
    end else if (adv_i) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage payload and bypass of the entry being written this cycle
  always_ff @(posedge clk) begin
    if (load_i) begin
      s1_req_r   <= req_i;
      fwd_r      <= s1_valid_r && s1_req_r.wr && (s1_req_r.addr == req_i.addr);
      fwd_data_r <= sum;
    end
  end

  // row store: write back on advance, read on load
  always_ff @(posedge clk) begin
    if (adv_i && s1_req_r.wr) begin
      mem[s1_req_r.addr] <= sum;
    end
    if (load_i) begin
      rd_q_r <= mem[req_i.addr];
    end
  end

  // neighbor selection and add
  always_comb begin
    above = s1_req_r.right ? '0 : (fwd_r ? fwd_data_r : rd_q_r);
    if (s1_req_r.top) begin
      best = '0;
    end else if (s1_req_r.first) begin
      best = above;
    end else if (s1_req_r.right) begin
      best = left_r;
    end else begin
      best = (left_r < above) ? left_r : above;
    end
    sum     = sat_add(s1_req_r.value, best);
    min_new = (s1_req_r.first || (sum < row_min_r)) ? sum : row_min_r;
  end

  // left neighbor and row minimum, cleared after each triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      row_min_r <= '0;
    end else if (adv_i) begin
      if (s1_req_r.last) begin
        left_r    <= '0;
        row_min_r <= '0;
      end else if (s1_req_r.wr) begin
        left_r    <= above;
        row_min_r <= min_new;
      end
    end
  end

  assign stat_o.busy        = s1_valid_r;
  assign stat_o.last        = s1_req_r.last;
  assign stat_o.shape_error = s1_req_r.err;
  assign stat_o.min_total   = s1_req_r.err ? '0 : min_new;

endmodule

// ===== sv/triangle_min_path_sum_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_min_path_sum_unit
// Streams a number triangle row by row and reports its minimum path sum.
// ----------------------------------------------------------------------------
// usage:
//   input channel: one triangle element per item, row-major from the top row,
//   row i carrying i+1 elements; in_last_element marks the final element.
//   output channel: one item per triangle, min_total and shape_error.
//   shape_error is set (and min_total is zero) when the rows exceed the row
//   store capacity or the last mark does not end a row.
// throughput: one element per cycle while in_stall is low; each element does a
//   single read and at most one write of the row store, the neighbor written
//   by the element before is bypassed around the store.
// result: the last element passes the sum stage, then the output register.
// reset: synchronous, active low; counters, flags and valids clear at once,
//   the row store needs no clearing, in_stall is high during reset.
// stall: a result waiting on out_stall is held in the output register; input
//   keeps flowing until a second last element reaches the sum stage, which
//   then holds and raises in_stall until the output register frees up.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_unit
  import tmps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_element_value,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_min_total,
  output logic        out_shape_error
);

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic              out_valid_r;
  sum_t              out_min_total_r;
  logic              out_shape_error_r;

  logic       accept;
  logic       ovf;
  logic       right;
  logic       s1_go;
  tmps_req_t  req;
  tmps_stat_t stat;

  // handshake
  assign s1_go    = stat.busy && !(stat.last && out_valid_r && out_stall);
  assign in_stall = !rst_n || (stat.busy && !s1_go);
  assign accept   = in_valid && !in_stall;

  // position decode of the incoming element
  assign ovf   = (row_r == ROW_W'(MAX_ROWS));
  assign right = (ROW_W'(col_r) == row_r);

  always_comb begin
    req.last  = in_last_element;
    req.err   = in_last_element && (ovf || ovf_seen_r || !right);
    req.wr    = !ovf;
    req.top   = (row_r == '0);
    req.first = (col_r == '0);
    req.right = right;
    req.addr  = col_r;
    req.value = val_t'(in_element_value);
  end

  // row and column counters
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    ovf_seen_nxt = ovf_seen_r;
    if (accept) begin
      if (in_last_element) begin
        row_nxt      = '0;
        col_nxt      = '0;
        ovf_seen_nxt = 1'b0;
      end else if (ovf) begin
        ovf_seen_nxt = 1'b1;
      end else if (right) begin
        row_nxt = row_r + 1'b1;
        col_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      ovf_seen_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      ovf_seen_r <= ovf_seen_nxt;
    end
  end

  tmps_sum_stage u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (accept),
    .req_i  (req),
    .adv_i  (s1_go),
    .stat_o (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && stat.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && stat.last) begin
      out_min_total_r   <= stat.min_total;
      out_shape_error_r <= stat.shape_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_total   = out_min_total_r;
  assign out_shape_error = out_shape_error_r;

endmodule

// ===== sv/tmps_chk.sv =====
// ----------------------------------------------------------------------------
// tmps_chk
// Port-level checks for the triangle minimum path sum unit.
// ----------------------------------------------------------------------------
`include "triangle_min_path_sum_unit_assert.svh"

module tmps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_element_value,
  input logic        in_last_element,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_min_total,
  input logic        out_shape_error
);

  // a stalled result item stays
  `TMPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result item dropped")

  // a stalled result payload holds
  `TMPS_HOLD(a_out_stable, out_valid && out_stall, out_min_total, "result changed")

  // error results carry a zero sum
  `TMPS_ASSERT(a_err_zero, out_valid && out_shape_error |-> out_min_total == 24'd0, "error sum")

  // a new result follows a taken last element, through the sum stage and output register
  `TMPS_ASSERT(a_rise_last,
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_element, 2),
    "result without last element")

endmodule

bind triangle_min_path_sum_unit tmps_chk u_tmps_chk (.*);

// ===== tb/triangle_min_path_sum_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_min_path_sum_unit_test
// Streams number triangles into the unit and checks each minimum path sum
// against a row-by-row predictor kept in the bench. Covers extreme values,
// early last marks, output back-pressure and random triangles with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_unit_test
  import tmps_pkg::*;
();

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 740;

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_MAX, FILL_MIN} fill_mode_t;

  typedef struct packed {
    sum_t min_total;
    logic shape_error;
  } path_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_element_value = '0;
  logic        in_last_element = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_min_total;
  logic        out_shape_error;

  // expected path sums, oldest first
  path_result_t pending_path_sums[$];
  int           failures = 0;
  int           items_sent = 0;
  bit           idle_en = 1'b1;
  bit           hold_request = 1'b0;
  bit           hold_active = 1'b0;

  // predictor state: best sums of the latest row and the walk position
  sum_t        best_row[MAX_ROWS];
  int unsigned walk_row = 0;
  int unsigned walk_col = 0;
  sum_t        left_before = '0;
  sum_t        row_low = '0;
  bit          too_many_rows = 1'b0;

  triangle_min_path_sum_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_min_total    (out_min_total),
    .out_shape_error  (out_shape_error)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // advance the path sums by one accepted element
  task automatic track_element(val_t value, logic last);
    sum_t                  above;
    sum_t                  best;
    sum_t                  s;
    logic signed [SUM_W+1:0] wide;
    bit                    early;
    path_result_t          res;
    early = 1'b0;
    if (walk_row >= MAX_ROWS) begin
      too_many_rows = 1'b1;
    end else begin
      early = last && (walk_col != walk_row);
      if (walk_row == 0) begin
        s = sum_t'(value);
      end else begin
        above = (walk_col < walk_row) ? best_row[walk_col] : '0;
        if (walk_col == 0) begin
          best = above;
        end else if (walk_col == walk_row) begin
          best = left_before;
        end else begin
          best = (left_before < above) ? left_before : above;
        end
        left_before = above;
        wide = (SUM_W+2)'(value) + (SUM_W+2)'(best);
        if (wide > SUM_MAX) begin
          s = SUM_MAX;
        end else if (wide < SUM_MIN) begin
          s = SUM_MIN;
        end else begin
          s = wide[SUM_W-1:0];
        end
      end
      best_row[walk_col] = s;
      if (walk_col == 0 || s < row_low) begin
        row_low = s;
      end
      if (walk_col >= walk_row) begin
        walk_row++;
        walk_col = 0;
      end else begin
        walk_col++;
      end
    end
    // a last mark closes the triangle and restarts the walk
    if (last) begin
      if (early || too_many_rows) begin
        res.min_total   = '0;
        res.shape_error = 1'b1;
      end else begin
        res.min_total   = row_low;
        res.shape_error = 1'b0;
      end
      pending_path_sums.push_back(res);
      walk_row      = 0;
      walk_col      = 0;
      left_before   = '0;
      row_low       = '0;
      too_many_rows = 1'b0;
    end
  endtask

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_en || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic val_t pick_value(fill_mode_t mode);
    case (mode)
      FILL_MAX: return 16'sh7FFF;
      FILL_MIN: return 16'sh8000;
      FILL_SMALL: return val_t'(int'($urandom_range(100)) - 50);
      FILL_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      default: return val_t'($urandom);
    endcase
  endfunction

  // offer one item and hold it until taken
  task automatic send_element(val_t value, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= value;
    in_last_element  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_element(value, last);
    items_sent++;
  endtask

  // rows of a triangle; a cut row at or above zero places the last mark at the cut position
  task automatic send_triangle(int rows, fill_mode_t mode, int cut_row, int cut_col);
    bit last;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c <= r; c++) begin
        last = (r == cut_row && c == cut_col) || (cut_row < 0 && r == rows - 1 && c == r);
        send_element(pick_value(mode), last);
        if (last) begin
          return;
        end
      end
    end
  endtask

  // sender pauses until every expected sum is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_path_sums.size() != 0) @(posedge clk);
  endtask

  // result checker
  initial begin : check_results
    path_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_path_sums.size() == 0) begin
          flag_failure($sformatf("unexpected result min_total=%0d shape_error=%0b",
                                 $signed(out_min_total), out_shape_error));
        end else begin
          want = pending_path_sums.pop_front();
          if (out_min_total !== want.min_total) begin
            flag_failure($sformatf("min_total expected %0d got %0d",
                                   want.min_total, $signed(out_min_total)));
          end
          if (out_shape_error !== want.shape_error) begin
            flag_failure($sformatf("shape_error expected %0b got %0b",
                                   want.shape_error, out_shape_error));
          end
        end
      end
    end
  end

  // result side stall: random bursts, or one long hold on request
  initial begin : drive_result_stall
    bit level;
    int run;
    level = 1'b0;
    run   = 0;
    forever begin
      if (hold_request) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        hold_active  = 1'b0;
      end else begin
        if (run == 0) begin
          level = !level;
          run = level ? (($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3))
                      : $urandom_range(1, 12);
        end
        run--;
        out_stall <= level && idle_en;
        @(posedge clk);
      end
    end
  end

  // extremes, worked examples and early last marks
  task automatic test_directed_shapes();
    send_element(val_t'(32767), 1'b1);
    send_element(val_t'(-32768), 1'b1);
    send_element(val_t'(2), 1'b0);
    send_element(val_t'(3), 1'b0);
    send_element(val_t'(4), 1'b0);
    send_element(val_t'(6), 1'b0);
    send_element(val_t'(5), 1'b0);
    send_element(val_t'(7), 1'b1);
    // last mark on the first element of row one
    send_element(val_t'(1), 1'b0);
    send_element(val_t'(2), 1'b1);
    send_element(val_t'(7), 1'b1);
    // last mark in the middle of row two
    send_element(val_t'(1), 1'b0);
    send_element(val_t'(-5), 1'b0);
    send_element(val_t'(9), 1'b0);
    send_element(val_t'(4), 1'b0);
    send_element(val_t'(8), 1'b1);
    // right edge path with opposite extremes
    send_element(val_t'(-32768), 1'b0);
    send_element(val_t'(32767), 1'b0);
    send_element(val_t'(-32768), 1'b1);
    send_element(val_t'(0), 1'b1);
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_output_backpressure();
    int rows;
    wait_drained();
    idle_en = 1'b0;
    hold_request = 1'b1;
    wait (hold_active);
    for (int t = 0; t < 6; t++) begin
      rows = $urandom_range(1, 3);
      send_triangle(rows, FILL_RANDOM, -1, 0);
    end
    wait_drained();
    idle_en = 1'b1;
  endtask

  // random triangles, mostly well formed, some cut short
  task automatic test_random_triangles();
    int         start;
    int         flip_at;
    int         rows;
    int         cut_row;
    int         cut_col;
    fill_mode_t mode;
    start   = items_sent;
    flip_at = items_sent + 120;
    while (items_sent - start < RANDOM_ITEMS) begin
      // alternate phases with and without idling
      if (items_sent >= flip_at) begin
        idle_en = !idle_en;
        flip_at = items_sent + $urandom_range(60, 160);
      end
      rows = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      mode = fill_mode_t'($urandom_range(2));
      cut_row = -1;
      cut_col = 0;
      if (rows > 1 && $urandom_range(99) < 15) begin
        cut_row = $urandom_range(1, rows - 1);
        cut_col = $urandom_range(0, cut_row - 1);
      end
      send_triangle(rows, mode, cut_row, cut_col);
      if ($urandom_range(19) == 0) begin
        wait_drained();
      end
    end
    idle_en = 1'b1;
  endtask

  // reset, tests in turn, final verdict
  initial begin
    for (int k = 0; k < MAX_ROWS; k++) begin
      best_row[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_shapes();
    test_output_backpressure();
    test_random_triangles();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
